>>> hdl/asst_pkg.sv
// ----------------------------------------------------------------------------
// asst_pkg
// Shared types, codes and defaults for the appliance step sequencer.
// ----------------------------------------------------------------------------
package asst_pkg;

  // Default table depth.
  localparam int DEF_MAX_STEPS = 16;

  // Configuration register indexes.
  localparam logic [1:0] CFG_STEP_COUNT = 2'd0;
  localparam logic [1:0] CFG_DEBOUNCE   = 2'd1;
  localparam logic [1:0] CFG_SAMPLE     = 2'd2;

  // Configuration reset values.
  localparam logic [4:0]  STEP_COUNT_RESET = 5'd0;
  localparam logic [15:0] DEBOUNCE_RESET   = 16'd500;
  localparam logic [15:0] SAMPLE_RESET     = 16'd50;

  // Request codes.
  localparam logic [2:0] REQ_TICK  = 3'd0;
  localparam logic [2:0] REQ_LOAD  = 3'd1;
  localparam logic [2:0] REQ_START = 3'd2;
  localparam logic [2:0] REQ_CLEAR = 3'd3;
  localparam logic [2:0] REQ_RESET = 3'd4;

  // Step kinds.
  localparam logic [2:0] KIND_FILL  = 3'd0;
  localparam logic [2:0] KIND_HEAT  = 3'd1;
  localparam logic [2:0] KIND_WASH  = 3'd2;
  localparam logic [2:0] KIND_DRAIN = 3'd3;
  localparam logic [2:0] KIND_WAIT  = 3'd4;

  // Run phases as reported on the phase output.
  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_RUN     = 3'd1,
    PH_FILLED  = 3'd2,
    PH_HEATED  = 3'd3,
    PH_WASHED  = 3'd4,
    PH_DRAINED = 3'd5,
    PH_ERROR   = 3'd6
  } phase_t;

  // Actuator enables.
  typedef struct packed {
    logic heat;
    logic pump;
    logic drain;
    logic fill;
  } drive_t;

  // One entry of the step table.
  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] duration;
  } step_entry_t;

  // Sequencer status after one request.
  typedef struct packed {
    drive_t drive;
    phase_t phase;
    logic   fault;
    logic   cycle_done;
    logic   clear_refused;
  } seq_status_t;

endpackage

>>> hdl/appliance_step_sequencer.sv
// ----------------------------------------------------------------------------
// appliance_step_sequencer
// Wash-cycle step sequencer driven by millisecond tick requests.
// ----------------------------------------------------------------------------
// Every request produces exactly one result carrying the actuator enables,
// phase, step pointer, fault and debounced levels as they stand after that
// request. A request passes an input register and is then processed into
// the result register, so one request is taken per clock when the result
// side keeps up. The step table is a memory with a registered read port
// that always holds the entry at the current step pointer. Table entries
// must be loaded before a started cycle reaches them. Configuration writes
// take effect at once; the user must make them while no request is in
// flight, as the block itself does not enforce this.
module appliance_step_sequencer
  import asst_pkg::*;
#(
  parameter int MAX_STEPS = DEF_MAX_STEPS,
  parameter int PW        = $clog2(MAX_STEPS + 1)
) (
  input  logic          clk,
  input  logic          rst,
  // Configuration port.
  input  logic          cfg_write,
  input  logic [1:0]    cfg_index,
  input  logic [15:0]   cfg_data,
  // Request channel.
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [2:0]    req_type,
  input  logic          raw_low_level,
  input  logic          raw_high_level,
  input  logic [3:0]    load_index,
  input  logic [2:0]    load_kind,
  input  logic [31:0]   load_duration_ms,
  // Result channel.
  output logic          out_valid,
  input  logic          out_ready,
  output logic          fill_valve,
  output logic          drain_valve,
  output logic          pump_on,
  output logic          heater_on,
  output logic [2:0]    phase,
  output logic [PW-1:0] current_step,
  output logic          fault_code,
  output logic          water_low_ok,
  output logic          water_high_ok,
  output logic          cycle_done,
  output logic          clear_refused
);

  localparam int AW = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;

  logic [4:0]  step_count;
  logic [15:0] debounce_ms;
  logic [15:0] sample_interval_ms;

  logic        in_full;
  logic [2:0]  q_req;
  logic [1:0]  q_raw;
  logic [3:0]  q_index;
  step_entry_t q_entry;

  logic        go;
  logic        tick;
  logic        load_en;
  logic [1:0]  stable_next;
  logic [1:0]  stable_now;
  step_entry_t cur_entry;
  seq_status_t status_next;
  logic [PW-1:0] ptr_next;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      step_count         <= STEP_COUNT_RESET;
      debounce_ms        <= DEBOUNCE_RESET;
      sample_interval_ms <= SAMPLE_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_STEP_COUNT: step_count <= cfg_data[4:0];
        CFG_DEBOUNCE:   debounce_ms <= cfg_data;
        CFG_SAMPLE:     sample_interval_ms <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Handshake: process when a request is held and the result slot frees up.
  assign go       = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || go;
  assign tick     = go && (q_req == REQ_TICK);
  assign load_en  = go && (q_req == REQ_LOAD) && (32'(q_index) < 32'(MAX_STEPS));

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      q_req            <= req_type;
      q_raw            <= {raw_high_level, raw_low_level};
      q_index          <= load_index;
      q_entry.kind     <= load_kind;
      q_entry.duration <= load_duration_ms;
    end
  end

  // Level switch debounce.
  asst_debounce u_debounce (
    .clk                (clk),
    .rst                (rst),
    .tick               (tick),
    .raw                (q_raw),
    .debounce_ms        (debounce_ms),
    .sample_interval_ms (sample_interval_ms),
    .stable_next        (stable_next)
  );

  // Levels before this request, taken from the result register.
  assign stable_now = {water_high_ok, water_low_ok};

  // Step table.
  asst_step_mem #(
    .DEPTH (MAX_STEPS),
    .AW    (AW)
  ) u_step_mem (
    .clk     (clk),
    .wr_en   (load_en),
    .wr_addr (AW'(q_index)),
    .wr_data (q_entry),
    .rd_addr (ptr_next[AW-1:0]),
    .rd_data (cur_entry)
  );

  // Run state.
  asst_sequencer #(
    .MAX_STEPS (MAX_STEPS),
    .PW        (PW)
  ) u_sequencer (
    .clk         (clk),
    .rst         (rst),
    .go          (go),
    .req         (q_req),
    .entry       (cur_entry),
    .step_count  (step_count),
    .stable_now  (stable_now),
    .stable_next (stable_next),
    .status_next (status_next),
    .ptr_next    (ptr_next)
  );

  // Result register. The level bits also serve as the debounced state view,
  // so they are reset along with the control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid     <= 1'b0;
      water_low_ok  <= 1'b0;
      water_high_ok <= 1'b0;
    end else if (go) begin
      out_valid     <= 1'b1;
      water_low_ok  <= stable_next[0];
      water_high_ok <= stable_next[1];
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      fill_valve    <= status_next.drive.fill;
      drain_valve   <= status_next.drive.drain;
      pump_on       <= status_next.drive.pump;
      heater_on     <= status_next.drive.heat;
      phase         <= status_next.phase;
      current_step  <= ptr_next;
      fault_code    <= status_next.fault;
      cycle_done    <= status_next.cycle_done;
      clear_refused <= status_next.clear_refused;
    end
  end

endmodule

>>> hdl/asst_debounce.sv
// ----------------------------------------------------------------------------
// asst_debounce
// Sampled debounce of the low and high level switches, advanced once per tick.
// ----------------------------------------------------------------------------
module asst_debounce
  import asst_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        tick,
  input  logic [1:0]  raw,
  input  logic [15:0] debounce_ms,
  input  logic [15:0] sample_interval_ms,
  output logic [1:0]  stable_next
);

  logic [15:0] sample_timer;
  logic [15:0] sample_timer_next;
  logic [1:0]  last_raw;
  logic [1:0]  last_raw_next;
  logic [15:0] hold_count [2];
  logic [15:0] hold_count_next [2];
  logic [1:0]  stable;
  logic [15:0] timer_inc;
  logic [15:0] hold_inc [2];
  logic        sample;

  // Next debounce state for a tick; held otherwise.
  always_comb begin
    timer_inc = (sample_timer == 16'hFFFF) ? sample_timer : sample_timer + 16'd1;
    sample = (timer_inc >= sample_interval_ms);
    sample_timer_next = sample ? 16'd0 : timer_inc;
    last_raw_next = last_raw;
    stable_next = stable;
    for (int i = 0; i < 2; i++) begin
      hold_inc[i] = (hold_count[i] == 16'hFFFF) ? hold_count[i] : hold_count[i] + 16'd1;
      hold_count_next[i] = hold_inc[i];
      if (sample && (raw[i] != last_raw[i])) begin
        last_raw_next[i] = raw[i];
        hold_count_next[i] = 16'd0;
      end
      if (sample && (hold_count_next[i] > debounce_ms)) begin
        stable_next[i] = raw[i];
      end
    end
    if (!tick) begin
      sample_timer_next = sample_timer;
      last_raw_next = last_raw;
      stable_next = stable;
      hold_count_next[0] = hold_count[0];
      hold_count_next[1] = hold_count[1];
    end
  end

  // Debounce state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_timer  <= 16'd0;
      last_raw      <= 2'b00;
      stable        <= 2'b00;
      hold_count[0] <= 16'd0;
      hold_count[1] <= 16'd0;
    end else begin
      sample_timer  <= sample_timer_next;
      last_raw      <= last_raw_next;
      stable        <= stable_next;
      hold_count[0] <= hold_count_next[0];
      hold_count[1] <= hold_count_next[1];
    end
  end

endmodule

>>> hdl/asst_step_mem.sv
// ----------------------------------------------------------------------------
// asst_step_mem
// Step table memory: one write port, one registered read port with
// write-through so the read data always matches the addressed entry.
// ----------------------------------------------------------------------------
module asst_step_mem
  import asst_pkg::*;
#(
  parameter int DEPTH = DEF_MAX_STEPS,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  step_entry_t   wr_data,
  input  logic [AW-1:0] rd_addr,
  output step_entry_t   rd_data
);

  step_entry_t mem [DEPTH];

  // Table write.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read, forwarding a write to the same entry.
  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr == rd_addr)) begin
      rd_data <= wr_data;
    end else begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hdl/asst_sequencer.sv
// ----------------------------------------------------------------------------
// asst_sequencer
// Run state of the wash cycle: phase, step pointer, elapsed time, drives and
// error, updated by one request per go.
// ----------------------------------------------------------------------------
module asst_sequencer
  import asst_pkg::*;
#(
  parameter int MAX_STEPS = DEF_MAX_STEPS,
  parameter int PW        = $clog2(MAX_STEPS + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          go,
  input  logic [2:0]    req,
  input  step_entry_t   entry,
  input  logic [4:0]    step_count,
  input  logic [1:0]    stable_now,
  input  logic [1:0]    stable_next,
  output seq_status_t   status_next,
  output logic [PW-1:0] ptr_next
);

  phase_t      phase;
  logic [PW-1:0] ptr;
  logic [31:0] elapsed;
  drive_t      drive;
  logic        fault;

  phase_t      phase_next;
  logic [31:0] elapsed_next;
  drive_t      drive_next;
  logic        fault_next;
  logic        done_pulse;
  logic        refused;
  logic [31:0] count;
  logic [31:0] elapsed_inc;
  logic        wet;
  logic        full;
  logic        timed_out;
  logic        step_done;
  logic [PW-1:0] ptr_work;

  // Effective step count, clipped to the table depth.
  assign count = (32'(step_count) > 32'(MAX_STEPS)) ? 32'(MAX_STEPS) : 32'(step_count);

  // Request handling.
  always_comb begin
    phase_next   = phase;
    ptr_work     = ptr;
    elapsed_next = elapsed;
    drive_next   = drive;
    fault_next   = fault;
    done_pulse   = 1'b0;
    refused      = 1'b0;
    step_done    = 1'b0;
    wet          = stable_next[0];
    full         = stable_next[1];
    elapsed_inc  = (elapsed == 32'hFFFF_FFFF) ? elapsed : elapsed + 32'd1;
    timed_out    = (entry.duration != 32'd0) && (elapsed_inc >= entry.duration);

    unique case (req)
      REQ_TICK: begin
        elapsed_next = elapsed_inc;
        if (phase == PH_ERROR) begin
          drive_next = '0;
        end else if (phase == PH_IDLE) begin
          ptr_work = '0;
        end else if (32'(ptr) >= count) begin
          phase_next = PH_IDLE;
          ptr_work   = '0;
          done_pulse = 1'b1;
        end else if ((entry.kind == KIND_HEAT) && !wet) begin
          fault_next      = 1'b1;
          phase_next      = PH_ERROR;
          drive_next.heat = 1'b0;
        end else begin
          // Drive the step and check its end condition.
          case (entry.kind)
            KIND_FILL: begin
              drive_next.fill = 1'b1;
              if (wet || full || timed_out) begin
                step_done  = 1'b1;
                phase_next = PH_FILLED;
              end
            end
            KIND_HEAT: begin
              drive_next.heat = 1'b1;
              if (timed_out) begin
                step_done  = 1'b1;
                phase_next = PH_HEATED;
              end
            end
            KIND_WASH: begin
              drive_next.pump = 1'b1;
              if (timed_out) begin
                step_done  = 1'b1;
                phase_next = PH_WASHED;
              end
            end
            KIND_DRAIN: begin
              drive_next.drain = 1'b1;
              drive_next.pump  = 1'b1;
              if (!wet || timed_out) begin
                step_done  = 1'b1;
                phase_next = PH_DRAINED;
              end
            end
            KIND_WAIT: begin
              if (timed_out) begin
                step_done  = 1'b1;
                phase_next = PH_IDLE;
              end
            end
            default: begin
              // End and unknown kinds finish at once.
              step_done = 1'b1;
            end
          endcase
          if (step_done) begin
            drive_next   = '0;
            ptr_work     = ptr + PW'(1);
            elapsed_next = 32'd0;
          end
        end
      end
      REQ_START: begin
        if (phase == PH_IDLE) begin
          phase_next   = PH_RUN;
          ptr_work     = '0;
          elapsed_next = 32'd0;
        end
      end
      REQ_CLEAR: begin
        if (phase == PH_ERROR) begin
          if (fault && !stable_now[0]) begin
            refused = 1'b1;
          end else begin
            fault_next = 1'b0;
            phase_next = PH_IDLE;
            ptr_work   = '0;
          end
        end
      end
      REQ_RESET: begin
        phase_next = PH_IDLE;
        ptr_work   = '0;
        drive_next = '0;
        fault_next = 1'b0;
      end
      default: begin
        // Table loads are handled by the memory; unknown requests do nothing.
      end
    endcase
  end

  assign ptr_next                  = go ? ptr_work : ptr;
  assign status_next.drive         = drive_next;
  assign status_next.phase         = phase_next;
  assign status_next.fault         = fault_next;
  assign status_next.cycle_done    = done_pulse;
  assign status_next.clear_refused = refused;

  // Run state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_IDLE;
      ptr     <= '0;
      elapsed <= 32'd0;
      drive   <= '0;
      fault   <= 1'b0;
    end else if (go) begin
      phase   <= phase_next;
      ptr     <= ptr_work;
      elapsed <= elapsed_next;
      drive   <= drive_next;
      fault   <= fault_next;
    end
  end

endmodule

>>> tb/appliance_step_sequencer_tb.sv
// ----------------------------------------------------------------------------
// appliance_step_sequencer_tb
// Self-checking testbench for the wash-cycle step sequencer.
// ----------------------------------------------------------------------------
// A behavioral copy of the sequencer runs beside the block. Every request
// taken on the input channel updates that copy, and the outputs it predicts
// are queued. Each result leaving the block is checked field by field
// against the oldest queued prediction. Directed tests walk through a full
// cycle and the low-water fault; random phases then run many cycles under
// changing register settings, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module appliance_step_sequencer_tb;
  import asst_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Request and kind codes that the package leaves unnamed.
  localparam logic [2:0] REQ_SPARE_LO  = 3'd5;
  localparam logic [2:0] REQ_SPARE_HI  = 3'd7;
  localparam logic [2:0] KIND_END      = 3'd5;
  localparam logic [2:0] KIND_SPARE_HI = 3'd7;

  // One request as it goes onto the input channel.
  typedef struct packed {
    logic [2:0]  rtype;
    logic        low;
    logic        high;
    logic [3:0]  idx;
    logic [2:0]  kind;
    logic [31:0] dur;
  } req_item_t;

  // The full set of outputs that one request leaves behind.
  typedef struct packed {
    drive_t     drive;
    phase_t     ph;
    logic [4:0] step;
    logic       fault;
    logic       low_ok;
    logic       high_ok;
    logic       done;
    logic       refused;
  } seq_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = 2'd0;
  logic [15:0] cfg_data = 16'd0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  req_type = 3'd0;
  logic        raw_low_level = 1'b0;
  logic        raw_high_level = 1'b0;
  logic [3:0]  load_index = 4'd0;
  logic [2:0]  load_kind = 3'd0;
  logic [31:0] load_duration_ms = 32'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        fill_valve;
  logic        drain_valve;
  logic        pump_on;
  logic        heater_on;
  logic [2:0]  phase;
  logic [4:0]  current_step;
  logic        fault_code;
  logic        water_low_ok;
  logic        water_high_ok;
  logic        cycle_done;
  logic        clear_refused;

  appliance_step_sequencer uut (.*);

  always #5 clk = ~clk;

  // Predicted sequencer state and register copies.
  step_entry_t tbl [DEF_MAX_STEPS];
  phase_t      seq_phase;
  logic [4:0]  seq_ptr;
  logic [31:0] seq_elapsed;
  drive_t      seq_drive;
  logic        seq_fault;
  logic [1:0]  lvl_stable;
  logic [1:0]  lvl_last;
  logic [15:0] lvl_hold [2];
  logic [15:0] smp_timer;
  logic [4:0]  cfg_steps;
  logic [15:0] cfg_debounce;
  logic [15:0] cfg_sample;

  seq_result_t pending_status [$];
  int          mismatches = 0;
  bit          idle_on = 1'b1;
  int          stall_left = 0;

  // Level switch debounce for one tick.
  function automatic void level_filter(logic lo, logic hi);
    logic [1:0] raw;
    raw = {hi, lo};
    if (smp_timer != 16'hFFFF) smp_timer++;
    for (int i = 0; i < 2; i++) begin
      if (lvl_hold[i] != 16'hFFFF) lvl_hold[i]++;
    end
    if (smp_timer < cfg_sample) return;
    smp_timer = 16'd0;
    for (int i = 0; i < 2; i++) begin
      if (raw[i] != lvl_last[i]) begin
        lvl_last[i] = raw[i];
        lvl_hold[i] = 16'd0;
      end
      if (lvl_hold[i] > cfg_debounce) lvl_stable[i] = raw[i];
    end
  endfunction

  // Step sequencing for one tick; returns the cycle-finished pulse.
  function automatic bit sequence_tick();
    logic [4:0]  limit;
    logic        wet;
    logic        full;
    logic        timed_out;
    logic        done;
    step_entry_t st;
    if (cfg_steps > 5'(DEF_MAX_STEPS)) limit = 5'(DEF_MAX_STEPS);
    else limit = cfg_steps;
    wet = lvl_stable[0];
    full = lvl_stable[1];
    done = 1'b0;
    if (seq_elapsed != 32'hFFFF_FFFF) seq_elapsed++;
    if (seq_phase == PH_ERROR) begin
      seq_drive = '0;
      return 1'b0;
    end
    if (seq_phase == PH_IDLE) begin
      seq_ptr = 5'd0;
      return 1'b0;
    end
    if (seq_ptr >= limit) begin
      seq_phase = PH_IDLE;
      seq_ptr = 5'd0;
      return 1'b1;
    end
    st = tbl[seq_ptr[3:0]];
    timed_out = (st.duration != 32'd0) && (seq_elapsed >= st.duration);
    // Heating with no water faults and leaves the other drives as they are.
    if (st.kind == KIND_HEAT && !wet) begin
      seq_fault = 1'b1;
      seq_phase = PH_ERROR;
      seq_drive.heat = 1'b0;
      return 1'b0;
    end
    case (st.kind)
      KIND_FILL: begin
        seq_drive.fill = 1'b1;
        if (wet || full || timed_out) begin
          done = 1'b1;
          seq_phase = PH_FILLED;
        end
      end
      KIND_HEAT: begin
        seq_drive.heat = 1'b1;
        if (timed_out) begin
          done = 1'b1;
          seq_phase = PH_HEATED;
        end
      end
      KIND_WASH: begin
        seq_drive.pump = 1'b1;
        if (timed_out) begin
          done = 1'b1;
          seq_phase = PH_WASHED;
        end
      end
      KIND_DRAIN: begin
        seq_drive.drain = 1'b1;
        seq_drive.pump = 1'b1;
        if (!wet || timed_out) begin
          done = 1'b1;
          seq_phase = PH_DRAINED;
        end
      end
      KIND_WAIT: begin
        if (timed_out) begin
          done = 1'b1;
          seq_phase = PH_IDLE;
        end
      end
      default: done = 1'b1;
    endcase
    if (done) begin
      seq_drive = '0;
      seq_ptr++;
      seq_elapsed = 32'd0;
    end
    return 1'b0;
  endfunction

  // Applies one request to the predicted state and returns the outputs after it.
  function automatic seq_result_t advance_sequencer(req_item_t r);
    seq_result_t res;
    logic        pulse;
    logic        refused;
    pulse = 1'b0;
    refused = 1'b0;
    case (r.rtype)
      REQ_TICK: begin
        level_filter(r.low, r.high);
        pulse = sequence_tick();
      end
      REQ_LOAD: begin
        tbl[r.idx].kind = r.kind;
        tbl[r.idx].duration = r.dur;
      end
      REQ_START: begin
        if (seq_phase == PH_IDLE) begin
          seq_phase = PH_RUN;
          seq_ptr = 5'd0;
          seq_elapsed = 32'd0;
        end
      end
      REQ_CLEAR: begin
        if (seq_phase == PH_ERROR) begin
          if (seq_fault && !lvl_stable[0]) begin
            refused = 1'b1;
          end else begin
            seq_fault = 1'b0;
            seq_phase = PH_IDLE;
            seq_ptr = 5'd0;
          end
        end
      end
      REQ_RESET: begin
        seq_phase = PH_IDLE;
        seq_ptr = 5'd0;
        seq_drive = '0;
        seq_fault = 1'b0;
      end
      default: ;
    endcase
    res.drive = seq_drive;
    res.ph = seq_phase;
    res.step = seq_ptr;
    res.fault = seq_fault;
    res.low_ok = lvl_stable[0];
    res.high_ok = lvl_stable[1];
    res.done = pulse;
    res.refused = refused;
    return res;
  endfunction

  function automatic string show_result(seq_result_t r);
    return $sformatf({"fill=%0b drain=%0b pump=%0b heat=%0b phase=%0d step=%0d ",
                      "fault=%0b low=%0b high=%0b done=%0b refused=%0b"},
                     r.drive.fill, r.drive.drain, r.drive.pump, r.drive.heat,
                     r.ph, r.step, r.fault, r.low_ok, r.high_ok, r.done, r.refused);
  endfunction

  // Names of the fields that disagree, empty when all match.
  function automatic string field_diffs(seq_result_t e, seq_result_t a);
    string s;
    s = "";
    if (e.drive.fill !== a.drive.fill) s = {s, " fill_valve"};
    if (e.drive.drain !== a.drive.drain) s = {s, " drain_valve"};
    if (e.drive.pump !== a.drive.pump) s = {s, " pump_on"};
    if (e.drive.heat !== a.drive.heat) s = {s, " heater_on"};
    if (e.ph !== a.ph) s = {s, " phase"};
    if (e.step !== a.step) s = {s, " current_step"};
    if (e.fault !== a.fault) s = {s, " fault_code"};
    if (e.low_ok !== a.low_ok) s = {s, " water_low_ok"};
    if (e.high_ok !== a.high_ok) s = {s, " water_high_ok"};
    if (e.done !== a.done) s = {s, " cycle_done"};
    if (e.refused !== a.refused) s = {s, " clear_refused"};
    return s;
  endfunction

  // Checks every result that leaves the block against the oldest prediction.
  always @(posedge clk) begin
    seq_result_t want;
    seq_result_t got;
    string       bad;
    if (!rst && out_valid && out_ready) begin
      got.drive = '{heat: heater_on, pump: pump_on, drain: drain_valve, fill: fill_valve};
      got.ph = phase_t'(phase);
      got.step = current_step;
      got.fault = fault_code;
      got.low_ok = water_low_ok;
      got.high_ok = water_high_ok;
      got.done = cycle_done;
      got.refused = clear_refused;
      if (pending_status.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with no request outstanding: %s", $time, show_result(got));
      end else begin
        want = pending_status.pop_front();
        bad = field_diffs(want, got);
        if (bad != "") begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: mismatch on%s\n  expected %s\n  actual   %s",
                     $time, bad, show_result(want), show_result(got));
        end
      end
    end
  end

  // Result side back-pressure in random bursts.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 5);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic req_item_t rand_item();
    req_item_t r;
    r.rtype = 3'($urandom_range(0, 7));
    r.low = 1'($urandom());
    r.high = 1'($urandom());
    r.idx = 4'($urandom());
    r.kind = 3'($urandom());
    r.dur = $urandom();
    return r;
  endfunction

  // Offers one request, waits for it to be taken and queues its prediction.
  task automatic send_request(req_item_t r);
    int gap;
    gap = 0;
    if (idle_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 6);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    req_type <= r.rtype;
    raw_low_level <= r.low;
    raw_high_level <= r.high;
    load_index <= r.idx;
    load_kind <= r.kind;
    load_duration_ms <= r.dur;
    do @(posedge clk); while (!in_ready);
    pending_status.push_back(advance_sequencer(r));
  endtask

  task automatic send_tick(logic lo, logic hi);
    req_item_t r;
    r = rand_item();
    r.rtype = REQ_TICK;
    r.low = lo;
    r.high = hi;
    send_request(r);
  endtask

  task automatic send_cmd(logic [2:0] code);
    req_item_t r;
    r = rand_item();
    r.rtype = code;
    send_request(r);
  endtask

  task automatic send_load(logic [3:0] idx, logic [2:0] kind, logic [31:0] dur);
    req_item_t r;
    r = rand_item();
    r.rtype = REQ_LOAD;
    r.idx = idx;
    r.kind = kind;
    r.dur = dur;
    send_request(r);
  endtask

  // Stops requests until every predicted result has come out.
  task automatic wait_results_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_write <= 1'b0;
    case (idx)
      CFG_STEP_COUNT: cfg_steps = data[4:0];
      CFG_DEBOUNCE:   cfg_debounce = data;
      CFG_SAMPLE:     cfg_sample = data;
      default: ;
    endcase
  endtask

  // Step count is five bits; the upper data bits are random filler.
  task automatic write_config(logic [4:0] steps, logic [15:0] deb, logic [15:0] smp);
    wait_results_drained();
    write_reg(CFG_STEP_COUNT, {11'($urandom()), steps});
    write_reg(CFG_DEBOUNCE, deb);
    write_reg(CFG_SAMPLE, smp);
  endtask

  // Idle requests under the reset register values, an empty cycle included.
  task automatic test_idle_requests();
    send_tick(1'b1, 1'b1);
    send_cmd(REQ_SPARE_LO);
    send_cmd(REQ_SPARE_HI);
    send_cmd(REQ_CLEAR);
    send_cmd(REQ_START);
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b0);
  endtask

  // One full cycle: fill, heat, wash, drain, an unknown kind, then done.
  task automatic test_step_sequence();
    write_config(5'd5, 16'd0, 16'd0);
    send_load(4'd0, KIND_FILL, 32'd0);
    send_load(4'd1, KIND_HEAT, 32'd2);
    send_load(4'd2, KIND_WASH, 32'd1);
    send_load(4'd3, KIND_DRAIN, 32'hFFFF_FFFF);
    send_load(4'd4, KIND_SPARE_HI, 32'd0);
    send_tick(1'b1, 1'b1);
    send_tick(1'b1, 1'b1);
    send_cmd(REQ_START);
    send_cmd(REQ_START);
    repeat (4) send_tick(1'b1, 1'b1);
    repeat (4) send_tick(1'b0, 1'b0);
  endtask

  // Heat step with no water: fault, refused clear, accepted clear, reset.
  task automatic test_low_water_fault();
    write_config(5'd5, 16'd0, 16'd1);
    send_load(4'd0, KIND_HEAT, 32'd5);
    send_cmd(REQ_START);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b0);
    send_cmd(REQ_CLEAR);
    send_tick(1'b1, 1'b0);
    send_tick(1'b1, 1'b0);
    send_cmd(REQ_CLEAR);
    send_cmd(REQ_START);
    send_cmd(REQ_RESET);
  endtask

  // Random cycles with random table content under changing register values.
  task automatic test_random_cycles();
    req_item_t r;
    int        sent;
    int        pick;
    logic      wlo;
    logic      whi;
    wlo = 1'b0;
    whi = 1'b0;
    // Every table entry is written before any cycle can reach it.
    for (int i = 0; i < DEF_MAX_STEPS; i++) begin
      r = rand_item();
      r.idx = 4'(i);
      r.kind = 3'($urandom_range(0, 4));
      r.dur = 32'($urandom_range(0, 6));
      r.rtype = REQ_LOAD;
      send_request(r);
    end
    for (int ph = 0; ph < 16; ph++) begin
      idle_on = (ph < 13) && (ph % 3 != 2);
      case (ph)
        0: write_config(5'd31, 16'hFFFF, 16'hFFFF);
        1: write_config(5'd16, 16'd0, 16'd0);
        2: write_config(5'd17, 16'd1, 16'd1);
        3: write_config(5'd0, 16'd2, 16'd1);
        default: begin
          if ($urandom_range(0, 9) == 0)
            write_config(5'($urandom_range(17, 31)), 16'($urandom_range(0, 6)),
                         16'($urandom_range(0, 3)));
          else
            write_config(5'($urandom_range(1, 16)), 16'($urandom_range(0, 6)),
                         16'($urandom_range(0, 3)));
        end
      endcase
      sent = 0;
      while (sent < 90) begin
        r = rand_item();
        pick = $urandom_range(0, 99);
        // An idle or faulted sequencer is sometimes nudged back into work.
        if (pick < 68 && seq_phase == PH_IDLE && $urandom_range(0, 3) == 0) pick = 70;
        if (pick < 68 && seq_phase == PH_ERROR && $urandom_range(0, 5) == 0) pick = 78;
        if (pick < 68) begin
          if ($urandom_range(0, 5) == 0) wlo = ~wlo;
          if ($urandom_range(0, 7) == 0) whi = ~whi;
          r.rtype = REQ_TICK;
          if ($urandom_range(0, 9) != 0) begin
            r.low = wlo;
            r.high = whi;
          end
        end else if (pick < 76) begin
          r.rtype = REQ_START;
        end else if (pick < 82) begin
          r.rtype = REQ_CLEAR;
        end else if (pick < 86) begin
          r.rtype = REQ_RESET;
        end else if (pick < 95) begin
          r.rtype = REQ_LOAD;
          if ($urandom_range(0, 9) == 0) r.kind = 3'($urandom_range(KIND_END, KIND_SPARE_HI));
          else r.kind = 3'($urandom_range(0, 4));
          case ($urandom_range(0, 9))
            0: r.dur = $urandom();
            1: r.dur = 32'hFFFF_FFFF;
            default: r.dur = 32'($urandom_range(0, 8));
          endcase
        end else begin
          r.rtype = 3'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI));
        end
        send_request(r);
        sent++;
      end
    end
  endtask

  // Run limit, far beyond the slowest passing run.
  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    for (int i = 0; i < DEF_MAX_STEPS; i++) tbl[i] = '0;
    seq_phase = PH_IDLE;
    seq_ptr = 5'd0;
    seq_elapsed = 32'd0;
    seq_drive = '0;
    seq_fault = 1'b0;
    lvl_stable = 2'b00;
    lvl_last = 2'b00;
    lvl_hold[0] = 16'd0;
    lvl_hold[1] = 16'd0;
    smp_timer = 16'd0;
    cfg_steps = STEP_COUNT_RESET;
    cfg_debounce = DEBOUNCE_RESET;
    cfg_sample = SAMPLE_RESET;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_idle_requests();
    test_step_sequence();
    test_low_water_fault();
    test_random_cycles();
    wait_results_drained();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
